### hw/rtl/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the Mandelbrot escape-time unit: number
// formats, register map, controller states and the command and status
// groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbe_pkg;

   // Number formats
   localparam int FRAC_BITS     = 28;                  // Q4.28 coordinates
   localparam int COORD_BITS    = 32;
   localparam int SPAN_BITS     = 31;
   localparam int PIX_BITS      = 12;
   localparam int DIM_BITS      = 13;
   localparam int MAX_DIM       = 4096;
   localparam int COUNT_BITS    = 16;
   localparam int QUO_BITS      = PIX_BITS + SPAN_BITS; // pixel * span
   localparam int MAP_BITS      = QUO_BITS + 2;         // mapped point before saturation
   localparam int Z_BITS        = FRAC_BITS + 3;        // |z| <= 2 inside the loop
   localparam int PROD_BITS     = 2 * Z_BITS;
   localparam int ORBIT_BITS    = FRAC_BITS + 8;        // new z before the bound test
   localparam int MAG_BITS      = 2 * FRAC_BITS + 4;    // |z|^2 in the product scale

   // Configuration port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Register reset values
   localparam logic signed [COORD_BITS-1:0] CENTER_RE_RST = -32'sd134217728;
   localparam logic signed [COORD_BITS-1:0] CENTER_IM_RST = 32'sd0;
   localparam logic [SPAN_BITS-1:0]         SPAN_RE_RST   = 31'd805306368;
   localparam logic [SPAN_BITS-1:0]         SPAN_IM_RST   = 31'd536870912;
   localparam logic [DIM_BITS-1:0]          WIDTH_RST     = 13'd640;
   localparam logic [DIM_BITS-1:0]          HEIGHT_RST    = 13'd480;
   localparam logic [COUNT_BITS-1:0]        LIMIT_RST     = 16'd256;

   // Register map, one word per register
   typedef enum logic [2:0] {
      CSR_CENTER_RE  = 3'd0,
      CSR_CENTER_IM  = 3'd1,
      CSR_SPAN_RE    = 3'd2,
      CSR_SPAN_IM    = 3'd3,
      CSR_WIDTH      = 3'd4,
      CSR_HEIGHT     = 3'd5,
      CSR_ITER_LIMIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] center_re;
      logic signed [COORD_BITS-1:0] center_im;
      logic [SPAN_BITS-1:0]         span_re;
      logic [SPAN_BITS-1:0]         span_im;
      logic [DIM_BITS-1:0]          image_width;
      logic [DIM_BITS-1:0]          image_height;
      logic [COUNT_BITS-1:0]        iteration_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_RE_GO,
      ST_DIV_RE_WAIT,
      ST_DIV_IM_GO,
      ST_DIV_IM_WAIT,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // take the pixel, form pixel * span
      logic div_start;  // start the serial divider
      logic div_sel;    // 0: real axis, 1: imaginary axis
      logic store_re;   // store real part of c
      logic store_im;   // store imaginary part of c, clear the orbit
      logic mul;        // form the three orbit products
      logic step;       // take the new z and bump the count
      logic finish;     // load the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic limit_zero;
      logic mag_esc;    // |z|^2 > 4 on the current orbit point
      logic comp_esc;   // a component of the new z is beyond 2
      logic limit_hit;  // the count reaches the limit on this step
   } sts_type;

endpackage

### hw/rtl/mbe_div.sv
// ----------------------------------------------------------------------------
// mbe_div
// Restoring divider, one quotient bit per cycle. Divides the pixel * span
// product by the image size in pixels.
// ----------------------------------------------------------------------------
module mbe_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [mbe_pkg::QUO_BITS-1:0] dividend,
   input  logic [mbe_pkg::DIM_BITS-1:0] divisor,
   output logic [mbe_pkg::QUO_BITS-1:0] quotient,
   output logic                         busy
);

   localparam int CNT_BITS = $clog2(mbe_pkg::QUO_BITS);

   logic [mbe_pkg::QUO_BITS-1:0] quo_ff, quo_in;
   logic [mbe_pkg::DIM_BITS-1:0] rem_ff, rem_in;
   logic [mbe_pkg::DIM_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_BITS-1:0]          cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic [mbe_pkg::DIM_BITS:0]   rem_sh;
   logic                         fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh = {rem_ff, quo_ff[mbe_pkg::QUO_BITS-1]};
      fits   = rem_sh >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_BITS'(mbe_pkg::QUO_BITS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[mbe_pkg::QUO_BITS-2:0], fits};
         rem_in = fits ? mbe_pkg::DIM_BITS'(rem_sh - {1'b0, dvs_ff})
                       : mbe_pkg::DIM_BITS'(rem_sh);
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;

endmodule

### hw/rtl/mbe_datapath.sv
// ----------------------------------------------------------------------------
// mbe_datapath
// Pixel to point mapping, the z = z*z + c orbit, escape tests, step count
// and the result register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module mbe_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  mbe_pkg::cfg_type               cfg,
   input  mbe_pkg::cmd_type               cmd,
   output mbe_pkg::sts_type               sts,
   input  logic [mbe_pkg::PIX_BITS-1:0]   req_pixel_x,
   input  logic [mbe_pkg::PIX_BITS-1:0]   req_pixel_y,
   output logic [mbe_pkg::COUNT_BITS-1:0] rsp_escape_count,
   output logic                           rsp_inside_set
);

   localparam int QB = mbe_pkg::QUO_BITS;
   localparam int MB = mbe_pkg::MAP_BITS;
   localparam int OB = mbe_pkg::ORBIT_BITS;
   localparam int PB = mbe_pkg::PROD_BITS;
   localparam int ZB = mbe_pkg::Z_BITS;
   localparam int CB = mbe_pkg::COUNT_BITS;
   localparam int DB = mbe_pkg::DIM_BITS;

   localparam logic signed [MB-1:0] C_MAX = MB'(64'sd2147483647);
   localparam logic signed [MB-1:0] C_MIN = -C_MAX - MB'(1);
   localparam logic signed [OB-1:0] ORBIT_TWO = OB'(1) <<< (mbe_pkg::FRAC_BITS + 1);
   localparam logic [mbe_pkg::MAG_BITS-1:0] FOUR_SQ =
      mbe_pkg::MAG_BITS'(1) << (2 * mbe_pkg::FRAC_BITS + 2);
   localparam logic [DB-1:0] DIM_MAX = DB'(mbe_pkg::MAX_DIM);

   logic [QB-1:0]                       prod_re_ff, prod_re_in;
   logic [QB-1:0]                       prod_im_ff, prod_im_in;
   logic signed [mbe_pkg::COORD_BITS-1:0] c_re_ff, c_re_in;
   logic signed [mbe_pkg::COORD_BITS-1:0] c_im_ff, c_im_in;
   logic signed [ZB-1:0]                zr_ff, zr_in;
   logic signed [ZB-1:0]                zi_ff, zi_in;
   logic signed [PB-1:0]                p_rr_ff, p_rr_in;
   logic signed [PB-1:0]                p_ii_ff, p_ii_in;
   logic signed [PB-1:0]                p_ri_ff, p_ri_in;
   logic                                chk_ff, chk_in;
   logic [CB-1:0]                       n_ff, n_in;
   logic [CB-1:0]                       count_ff, count_in;
   logic                                inside_ff, inside_in;

   logic [DB-1:0]          dim_w, dim_h;
   logic [QB-1:0]          quo;
   logic                   div_busy;
   logic signed [MB-1:0]   map_re, map_im;
   logic signed [PB:0]     diff;
   logic signed [OB-1:0]   nr, ni;
   logic [mbe_pkg::MAG_BITS-1:0] mag_sum;

   // Image size, zero read as one and large sizes held at the maximum
   always_comb begin
      dim_w = cfg.image_width;
      if (cfg.image_width == '0) begin
         dim_w = DB'(1);
      end else if (cfg.image_width > DIM_MAX) begin
         dim_w = DIM_MAX;
      end
      dim_h = cfg.image_height;
      if (cfg.image_height == '0) begin
         dim_h = DB'(1);
      end else if (cfg.image_height > DIM_MAX) begin
         dim_h = DIM_MAX;
      end
   end

   mbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (cmd.div_sel ? prod_im_ff : prod_re_ff),
      .divisor  (cmd.div_sel ? dim_h : dim_w),
      .quotient (quo),
      .busy     (div_busy)
   );

   // Point mapping around the view center
   always_comb begin
      map_re = MB'(cfg.center_re)
             - MB'($signed({1'b0, cfg.span_re[mbe_pkg::SPAN_BITS-1:1]}))
             + MB'($signed({1'b0, quo}));
      map_im = MB'(cfg.center_im)
             + MB'($signed({1'b0, cfg.span_im[mbe_pkg::SPAN_BITS-1:1]}))
             - MB'($signed({1'b0, quo}));
   end

   // New orbit point from the registered products
   always_comb begin
      diff    = (PB+1)'(p_rr_ff) - (PB+1)'(p_ii_ff);
      nr      = OB'(diff >>> mbe_pkg::FRAC_BITS) + OB'(c_re_ff);
      ni      = OB'(p_ri_ff >>> (mbe_pkg::FRAC_BITS - 1)) + OB'(c_im_ff);
      mag_sum = p_rr_ff[mbe_pkg::MAG_BITS-1:0] + p_ii_ff[mbe_pkg::MAG_BITS-1:0];
   end

   // Status back to the controller
   always_comb begin
      sts.div_done   = !div_busy;
      sts.limit_zero = cfg.iteration_limit == '0;
      sts.mag_esc    = chk_ff && (mag_sum > FOUR_SQ);
      sts.comp_esc   = (nr > ORBIT_TWO) || (nr < -ORBIT_TWO) ||
                       (ni > ORBIT_TWO) || (ni < -ORBIT_TWO);
      sts.limit_hit  = chk_ff &&
                       (({1'b0, n_ff} + (CB+1)'(1)) == {1'b0, cfg.iteration_limit});
   end

   // Next values
   always_comb begin
      prod_re_in = prod_re_ff;
      prod_im_in = prod_im_ff;
      c_re_in    = c_re_ff;
      c_im_in    = c_im_ff;
      zr_in      = zr_ff;
      zi_in      = zi_ff;
      p_rr_in    = p_rr_ff;
      p_ii_in    = p_ii_ff;
      p_ri_in    = p_ri_ff;
      chk_in     = chk_ff;
      n_in       = n_ff;
      count_in   = count_ff;
      inside_in  = inside_ff;

      if (cmd.load) begin
         prod_re_in = QB'(req_pixel_x) * QB'(cfg.span_re);
         prod_im_in = QB'(req_pixel_y) * QB'(cfg.span_im);
      end

      // saturate the mapped point to Q4.28
      if (cmd.store_re) begin
         if (map_re > C_MAX) begin
            c_re_in = C_MAX[mbe_pkg::COORD_BITS-1:0];
         end else if (map_re < C_MIN) begin
            c_re_in = C_MIN[mbe_pkg::COORD_BITS-1:0];
         end else begin
            c_re_in = map_re[mbe_pkg::COORD_BITS-1:0];
         end
      end
      if (cmd.store_im) begin
         if (map_im > C_MAX) begin
            c_im_in = C_MAX[mbe_pkg::COORD_BITS-1:0];
         end else if (map_im < C_MIN) begin
            c_im_in = C_MIN[mbe_pkg::COORD_BITS-1:0];
         end else begin
            c_im_in = map_im[mbe_pkg::COORD_BITS-1:0];
         end
         zr_in   = '0;
         zi_in   = '0;
         p_rr_in = '0;
         p_ii_in = '0;
         p_ri_in = '0;
         chk_in  = 1'b0;
         n_in    = '0;
      end

      if (cmd.mul) begin
         p_rr_in = PB'(zr_ff) * PB'(zr_ff);
         p_ii_in = PB'(zi_ff) * PB'(zi_ff);
         p_ri_in = PB'(zr_ff) * PB'(zi_ff);
      end

      // the first step has no orbit point to count yet
      if (cmd.step) begin
         if (chk_ff) begin
            n_in = n_ff + CB'(1);
         end
         if (!sts.comp_esc) begin
            zr_in  = nr[ZB-1:0];
            zi_in  = ni[ZB-1:0];
            chk_in = 1'b1;
         end
      end

      if (cmd.finish) begin
         count_in  = n_ff;
         inside_in = n_ff == cfg.iteration_limit;
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      c_re_ff    <= c_re_in;
      c_im_ff    <= c_im_in;
      zr_ff      <= zr_in;
      zi_ff      <= zi_in;
      p_rr_ff    <= p_rr_in;
      p_ii_ff    <= p_ii_in;
      p_ri_ff    <= p_ri_in;
      chk_ff     <= chk_in;
      n_ff       <= n_in;
      count_ff   <= count_in;
      inside_ff  <= inside_in;
   end

   assign rsp_escape_count = count_ff;
   assign rsp_inside_set   = inside_ff;

endmodule

### hw/rtl/mbe_ctrl.sv
// ----------------------------------------------------------------------------
// mbe_ctrl
// Sequencer for one pixel: two divisions for the point mapping, then the
// multiply / add loop until escape or limit, then the result beat.
// ----------------------------------------------------------------------------
module mbe_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mbe_pkg::cmd_type cmd,
   input  mbe_pkg::sts_type sts
);

   mbe_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         mbe_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = mbe_pkg::ST_DIV_RE_GO;
            end
         end
         mbe_pkg::ST_DIV_RE_GO: begin
            cmd.div_start = 1'b1;
            state_in      = mbe_pkg::ST_DIV_RE_WAIT;
         end
         mbe_pkg::ST_DIV_RE_WAIT: begin
            if (sts.div_done) begin
               cmd.store_re = 1'b1;
               state_in     = mbe_pkg::ST_DIV_IM_GO;
            end
         end
         mbe_pkg::ST_DIV_IM_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = 1'b1;
            state_in      = mbe_pkg::ST_DIV_IM_WAIT;
         end
         mbe_pkg::ST_DIV_IM_WAIT: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin
               cmd.store_im = 1'b1;
               state_in     = sts.limit_zero ? mbe_pkg::ST_DONE : mbe_pkg::ST_MUL;
            end
         end
         mbe_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = mbe_pkg::ST_ADD;
         end
         mbe_pkg::ST_ADD: begin
            // escape on magnitude keeps the count as it is
            if (sts.mag_esc) begin
               state_in = mbe_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = (sts.limit_hit || sts.comp_esc) ? mbe_pkg::ST_DONE
                                                          : mbe_pkg::ST_MUL;
            end
         end
         mbe_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = mbe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mbe_pkg::ST_IDLE;
         end
      endcase
   end

   // Result beat: held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != mbe_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // Checks
   a_accept_starts_map: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == mbe_pkg::ST_DIV_RE_GO))
      else $error("accepted beat did not start the mapping");

   a_finish_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while still waiting");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_mul_then_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbe_pkg::ST_MUL) |=> (state_ff == mbe_pkg::ST_ADD))
      else $error("products not followed by orbit update");

endmodule

### hw/rtl/mandelbrot_escape_time_unit.sv
// The unit takes one pixel coordinate per beat, maps it to a point c of the
// complex plane from the view registers (Q4.28 center, Q3.28 unsigned
// span, image size), and iterates z = z*z + c from zero until |z| exceeds 2
// or the iteration limit is reached. The mapping uses a bit-serial divider
// on each axis, and each iteration forms the three orbit products and then
// does the add and the escape tests. Pixels are handled one at a time; a
// finished result waits in an output register, so the next pixel is taken
// while the result is still pending.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Top level: configuration registers on an APB-style port, controller and
// datapath.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit (
   input  logic                              clock,
   input  logic                              reset,
   // pixel channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mbe_pkg::PIX_BITS-1:0]      req_pixel_x,
   input  logic [mbe_pkg::PIX_BITS-1:0]      req_pixel_y,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mbe_pkg::COUNT_BITS-1:0]    rsp_escape_count,
   output logic                              rsp_inside_set,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mbe_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   localparam int DW = mbe_pkg::CSR_DATA_BITS;

   mbe_pkg::cfg_type       cfg_ff, cfg_in;
   mbe_pkg::cmd_type       cmd;
   mbe_pkg::sts_type       sts;
   mbe_pkg::csr_index_type csr_idx;
   logic                   csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = mbe_pkg::csr_index_type'(csr_paddr[mbe_pkg::CSR_ADDR_BITS-1:2]);

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            mbe_pkg::CSR_CENTER_RE:  cfg_in.center_re = csr_pwdata;
            mbe_pkg::CSR_CENTER_IM:  cfg_in.center_im = csr_pwdata;
            mbe_pkg::CSR_SPAN_RE:    cfg_in.span_re = csr_pwdata[mbe_pkg::SPAN_BITS-1:0];
            mbe_pkg::CSR_SPAN_IM:    cfg_in.span_im = csr_pwdata[mbe_pkg::SPAN_BITS-1:0];
            mbe_pkg::CSR_WIDTH:      cfg_in.image_width = csr_pwdata[mbe_pkg::DIM_BITS-1:0];
            mbe_pkg::CSR_HEIGHT:     cfg_in.image_height = csr_pwdata[mbe_pkg::DIM_BITS-1:0];
            mbe_pkg::CSR_ITER_LIMIT: begin
               cfg_in.iteration_limit = csr_pwdata[mbe_pkg::COUNT_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_re       <= mbe_pkg::CENTER_RE_RST;
         cfg_ff.center_im       <= mbe_pkg::CENTER_IM_RST;
         cfg_ff.span_re         <= mbe_pkg::SPAN_RE_RST;
         cfg_ff.span_im         <= mbe_pkg::SPAN_IM_RST;
         cfg_ff.image_width     <= mbe_pkg::WIDTH_RST;
         cfg_ff.image_height    <= mbe_pkg::HEIGHT_RST;
         cfg_ff.iteration_limit <= mbe_pkg::LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Register reads
   always_comb begin
      case (csr_idx)
         mbe_pkg::CSR_CENTER_RE:  csr_prdata = cfg_ff.center_re;
         mbe_pkg::CSR_CENTER_IM:  csr_prdata = cfg_ff.center_im;
         mbe_pkg::CSR_SPAN_RE:    csr_prdata = DW'(cfg_ff.span_re);
         mbe_pkg::CSR_SPAN_IM:    csr_prdata = DW'(cfg_ff.span_im);
         mbe_pkg::CSR_WIDTH:      csr_prdata = DW'(cfg_ff.image_width);
         mbe_pkg::CSR_HEIGHT:     csr_prdata = DW'(cfg_ff.image_height);
         mbe_pkg::CSR_ITER_LIMIT: csr_prdata = DW'(cfg_ff.iteration_limit);
         default:                 csr_prdata = '0;
      endcase
   end

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   mbe_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .sts              (sts),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_escape_count (rsp_escape_count),
      .rsp_inside_set   (rsp_inside_set)
   );

endmodule

### dv/mandelbrot_escape_time_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_checker
// Watches the pixel, result and register ports of the escape-time unit. Keeps
// a shadow copy of the view registers and computes the escape count and the
// inside flag of every accepted pixel. Each result beat is then compared with
// the oldest pending prediction. Passes the failure count and the number of
// pending predictions up to the bench.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_checker (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   input  logic                                       req_stall,
   input  logic [mbe_pkg::PIX_BITS-1:0]               req_pixel_x,
   input  logic [mbe_pkg::PIX_BITS-1:0]               req_pixel_y,
   input  logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   input  logic [mbe_pkg::COUNT_BITS-1:0]             rsp_escape_count,
   input  logic                                       rsp_inside_set,
   input  logic                                       csr_psel,
   input  logic                                       csr_penable,
   input  logic                                       csr_pwrite,
   input  logic [mbe_pkg::CSR_ADDR_BITS-1:0]          csr_paddr,
   input  logic [mbe_pkg::CSR_DATA_BITS-1:0]          csr_pwdata,
   input  logic                                       csr_pready,
   output int unsigned                                error_count,
   output int unsigned                                outstanding
);

   typedef struct packed {
      logic [mbe_pkg::COUNT_BITS-1:0] escape_count;
      logic                           inside_set;
   } escape_result_type;

   // Shadow of the view registers
   logic signed [mbe_pkg::COORD_BITS-1:0] view_center_re;
   logic signed [mbe_pkg::COORD_BITS-1:0] view_center_im;
   logic [mbe_pkg::SPAN_BITS-1:0]         view_span_re;
   logic [mbe_pkg::SPAN_BITS-1:0]         view_span_im;
   logic [mbe_pkg::DIM_BITS-1:0]          view_width;
   logic [mbe_pkg::DIM_BITS-1:0]          view_height;
   logic [mbe_pkg::COUNT_BITS-1:0]        view_limit;

   escape_result_type pending_results[$];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // zero size counts as one, anything above the largest image is clamped
   function automatic longint clamp_dim(input logic [mbe_pkg::DIM_BITS-1:0] d);
      if (d == '0)
         return 1;
      if (d > mbe_pkg::MAX_DIM)
         return mbe_pkg::MAX_DIM;
      return longint'(d);
   endfunction

   function automatic longint saturate(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi)
         return hi;
      if (v < lo)
         return lo;
      return v;
   endfunction

   // Map the pixel into the plane and run the orbit until escape or limit
   function automatic escape_result_type iterate_pixel(
      input logic [mbe_pkg::PIX_BITS-1:0] px,
      input logic [mbe_pkg::PIX_BITS-1:0] py);
      longint w, h, cr, ci, zr, zi, nr, ni, ar, ai;
      longint two, four_sq;
      int unsigned n;
      escape_result_type res;
      w = clamp_dim(view_width);
      h = clamp_dim(view_height);
      two = 64'sd1 <<< (mbe_pkg::FRAC_BITS + 1);
      four_sq = 64'sd4 <<< (2 * mbe_pkg::FRAC_BITS);
      cr = longint'(view_center_re) - (longint'(view_span_re) >>> 1)
           + (longint'(px) * longint'(view_span_re)) / w;
      ci = longint'(view_center_im) + (longint'(view_span_im) >>> 1)
           - (longint'(py) * longint'(view_span_im)) / h;
      cr = saturate(cr, mbe_pkg::COORD_BITS);
      ci = saturate(ci, mbe_pkg::COORD_BITS);
      zr = 0;
      zi = 0;
      n = 0;
      while (n < view_limit) begin
         // components are within 2 here, so the products fit in 64 bits
         nr = ((zr * zr - zi * zi) >>> mbe_pkg::FRAC_BITS) + cr;
         ni = ((2 * zr * zi) >>> mbe_pkg::FRAC_BITS) + ci;
         zr = saturate(nr, mbe_pkg::ORBIT_BITS);
         zi = saturate(ni, mbe_pkg::ORBIT_BITS);
         ar = (zr < 0) ? -zr : zr;
         ai = (zi < 0) ? -zi : zi;
         if (ar > two || ai > two)
            break;
         if (ar * ar + ai * ai > four_sq)
            break;
         n++;
      end
      res.escape_count = n[mbe_pkg::COUNT_BITS-1:0];
      res.inside_set   = (n == view_limit);
      return res;
   endfunction

   always @(posedge clock) begin
      escape_result_type want;
      if (reset) begin
         view_center_re = mbe_pkg::CENTER_RE_RST;
         view_center_im = mbe_pkg::CENTER_IM_RST;
         view_span_re   = mbe_pkg::SPAN_RE_RST;
         view_span_im   = mbe_pkg::SPAN_IM_RST;
         view_width     = mbe_pkg::WIDTH_RST;
         view_height    = mbe_pkg::HEIGHT_RST;
         view_limit     = mbe_pkg::LIMIT_RST;
         pending_results.delete();
      end else begin
         // register writes; unknown indexes are dropped
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[mbe_pkg::CSR_ADDR_BITS-1:2])
               mbe_pkg::CSR_CENTER_RE:  view_center_re = csr_pwdata;
               mbe_pkg::CSR_CENTER_IM:  view_center_im = csr_pwdata;
               mbe_pkg::CSR_SPAN_RE:    view_span_re   = csr_pwdata[mbe_pkg::SPAN_BITS-1:0];
               mbe_pkg::CSR_SPAN_IM:    view_span_im   = csr_pwdata[mbe_pkg::SPAN_BITS-1:0];
               mbe_pkg::CSR_WIDTH:      view_width     = csr_pwdata[mbe_pkg::DIM_BITS-1:0];
               mbe_pkg::CSR_HEIGHT:     view_height    = csr_pwdata[mbe_pkg::DIM_BITS-1:0];
               mbe_pkg::CSR_ITER_LIMIT: view_limit     = csr_pwdata[mbe_pkg::COUNT_BITS-1:0];
               default: ;
            endcase
         end
         // result beat first, so a pixel taken on the same edge cannot match it
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: result beat with nothing pending: escape_count %0d inside_set %0b",
                        $time, rsp_escape_count, rsp_inside_set);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_escape_count !== want.escape_count) begin
                  $display("%0t: escape_count mismatch: expected %0d, actual %0d",
                           $time, want.escape_count, rsp_escape_count);
                  error_count++;
               end
               if (rsp_inside_set !== want.inside_set) begin
                  $display("%0t: inside_set mismatch: expected %0b, actual %0b",
                           $time, want.inside_set, rsp_inside_set);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_results = {pending_results, iterate_pixel(req_pixel_x, req_pixel_y)};
      end
      outstanding <= pending_results.size();
   end

endmodule

### dv/mandelbrot_escape_time_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit_tb
// Bench for the escape-time unit. Runs a short directed set on the reset view
// and on corner views (zero limit, zero and oversized image, extreme centers,
// largest limit), then random views with random pixels, some outside the
// image. Both channels idle in random bursts, once the result side holds off
// long enough to back up the pixel side. Checking is done in the checker.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit_tb;

   localparam int          CLK_PERIOD       = 8;
   localparam int          RESET_CYCLES     = 10;
   localparam int          RANDOM_PHASES    = 12;
   localparam int          PHASE_PIXELS     = 100;
   localparam int          HOLD_OFF_CYCLES  = 2500;
   localparam int          DRAIN_CYCLES     = 8;
   localparam int          END_CYCLES       = 300;
   localparam int unsigned CYCLE_LIMIT      = 2_500_000;
   localparam logic [2:0]  CSR_UNUSED_IDX   = 3'd7;
   localparam int          ONE_Q            = 1 << mbe_pkg::FRAC_BITS;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [mbe_pkg::PIX_BITS-1:0]      req_pixel_x;
   logic [mbe_pkg::PIX_BITS-1:0]      req_pixel_y;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [mbe_pkg::COUNT_BITS-1:0]    rsp_escape_count;
   logic                              rsp_inside_set;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [mbe_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [mbe_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   int unsigned error_count;
   int unsigned outstanding;
   int unsigned cycle_count = 0;
   bit          idle_on = 1'b1;
   bit          hold_off_request = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   mandelbrot_escape_time_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_escape_count (rsp_escape_count),
      .rsp_inside_set   (rsp_inside_set),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   mandelbrot_escape_time_checker u_escape_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_escape_count (rsp_escape_count),
      .rsp_inside_set   (rsp_inside_set),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Setup and access phases of one register write, then the bus idles
   task automatic csr_write(input logic [2:0] idx,
                            input logic [mbe_pkg::CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Whole view; unused upper bits carry noise
   task automatic apply_view(input logic [mbe_pkg::COORD_BITS-1:0] cre,
                             input logic [mbe_pkg::COORD_BITS-1:0] cim,
                             input logic [mbe_pkg::SPAN_BITS-1:0]  sre,
                             input logic [mbe_pkg::SPAN_BITS-1:0]  sim,
                             input logic [mbe_pkg::DIM_BITS-1:0]   w,
                             input logic [mbe_pkg::DIM_BITS-1:0]   h,
                             input logic [mbe_pkg::COUNT_BITS-1:0] lim);
      csr_write(mbe_pkg::CSR_CENTER_RE, cre);
      csr_write(mbe_pkg::CSR_CENTER_IM, cim);
      csr_write(mbe_pkg::CSR_SPAN_RE, {1'($urandom), sre});
      csr_write(mbe_pkg::CSR_SPAN_IM, {1'($urandom), sim});
      csr_write(mbe_pkg::CSR_WIDTH, {19'($urandom), w});
      csr_write(mbe_pkg::CSR_HEIGHT, {19'($urandom), h});
      csr_write(mbe_pkg::CSR_ITER_LIMIT, {16'($urandom), lim});
   endtask

   // One pixel beat, with an occasional gap in front
   task automatic send_pixel(input logic [mbe_pkg::PIX_BITS-1:0] x,
                             input logic [mbe_pkg::PIX_BITS-1:0] y);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Stop offering and wait until every result is back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: random stall bursts, one long hold-off on request
   initial begin : result_side
      rsp_stall = 1'b0;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      logic [mbe_pkg::COORD_BITS-1:0] cre, cim;
      logic [mbe_pkg::SPAN_BITS-1:0]  sre, sim;
      logic [mbe_pkg::DIM_BITS-1:0]   w, h;
      logic [mbe_pkg::COUNT_BITS-1:0] lim;
      logic [mbe_pkg::PIX_BITS-1:0]   px, py;
      int                             eff_w, eff_h;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset view: corners, far outside, inside, the c = -2 boundary, cusp
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd639, 12'd479);
      send_pixel(12'd320, 12'd240);
      send_pixel(12'd160, 12'd240);
      send_pixel(12'd0, 12'd240);
      send_pixel(12'd480, 12'd240);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd2730, 12'd1365);
      wait_idle();

      // Zero image size acts as one pixel; pixels beyond extrapolate
      csr_write(CSR_UNUSED_IDX, $urandom());
      apply_view(-32'sd134217728, 32'sd0, 31'd805306368, 31'd536870912, 13'd0, 13'd0, 16'd20);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd1, 12'd1);
      send_pixel(12'd4095, 12'd4095);
      wait_idle();

      // Zero limit, oversized image clamped to the largest size
      apply_view(-32'sd134217728, 32'sd0, 31'd805306368, 31'd536870912, 13'd8191, 13'd4097,
                 16'd0);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd4095, 12'd4095);
      wait_idle();

      // Extreme centers and spans, mapping saturates
      apply_view(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 13'd1, 13'd1,
                 16'd16);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      wait_idle();

      // Largest limit on the origin: the orbit never leaves
      apply_view(32'sd0, 32'sd0, 31'd0, 31'd0, 13'd4096, 13'd4096, 16'hFFFF);
      send_pixel(12'd7, 12'd9);
      wait_idle();

      // Random views
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase < RANDOM_PHASES - 2) && (phase != 2);
         if (phase == 0) begin
            cre = -32'sd134217728;
            cim = 32'sd0;
            sre = 31'd805306368;
            sim = 31'd536870912;
         end else begin
            if ($urandom_range(0, 4) != 0) begin
               cre = int'($urandom_range(0, 4 * ONE_Q)) - (5 * ONE_Q / 2);
               cim = int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q;
            end else begin
               cre = $urandom();
               cim = $urandom();
            end
            case ($urandom_range(0, 9))
               0:       sre = '0;
               1:       sre = 31'($urandom());
               default: sre = 31'($urandom_range(1 << 20, 4 * ONE_Q));
            endcase
            case ($urandom_range(0, 9))
               0:       sim = '0;
               1:       sim = 31'($urandom());
               default: sim = 31'($urandom_range(1 << 20, 4 * ONE_Q));
            endcase
         end
         case ($urandom_range(0, 9))
            0:       w = '0;
            1:       w = 13'($urandom_range(mbe_pkg::MAX_DIM + 1, 8191));
            default: w = 13'($urandom_range(1, mbe_pkg::MAX_DIM));
         endcase
         case ($urandom_range(0, 9))
            0:       h = '0;
            1:       h = 13'($urandom_range(mbe_pkg::MAX_DIM + 1, 8191));
            default: h = 13'($urandom_range(1, mbe_pkg::MAX_DIM));
         endcase
         lim = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 64));
         apply_view(cre, cim, sre, sim, w, h, lim);
         eff_w = (w == '0) ? 1 : ((int'(w) > mbe_pkg::MAX_DIM) ? mbe_pkg::MAX_DIM : int'(w));
         eff_h = (h == '0) ? 1 : ((int'(h) > mbe_pkg::MAX_DIM) ? mbe_pkg::MAX_DIM : int'(h));
         // result side backs off while pixels keep coming
         if (phase == 2)
            hold_off_request = 1'b1;
         for (int i = 0; i < PHASE_PIXELS; i++) begin
            if ($urandom_range(0, 9) < 8) begin
               px = 12'($urandom_range(0, eff_w - 1));
               py = 12'($urandom_range(0, eff_h - 1));
            end else begin
               px = 12'($urandom());
               py = 12'($urandom());
            end
            send_pixel(px, py);
         end
         wait_idle();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0 && outstanding == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
